>>> rtl/cosd_pkg.sv
// Package: payload types, widths and shared constants for the cosine distance block.
`default_nettype none
package cosd_pkg;
  localparam int ELEM_BITS = 16;
  localparam int SUM_W = 48;
  localparam int NORM_W = 62;
  localparam int ROOT_W = 31;
  localparam int DEN_W = 62;
  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic signed [15:0] a_elem;
    logic signed [15:0] b_elem;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic [31:0] distance;
    logic        zero_norm;
  } out_item_t;

  // Finished sums of one vector pair, handed from front to back.
  typedef struct packed {
    logic signed [SUM_W-1:0] dot;
    logic [SUM_W-1:0]        a_norm;
    logic [SUM_W-1:0]        b_norm;
  } sums_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_SQRT,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } back_state_t;
endpackage
`default_nettype wire

>>> rtl/cosd_front.sv
// Front end: accumulates the three running sums and emits them on the last pair.
`default_nettype none
module cosd_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cosd_pkg::in_item_t in_data,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output cosd_pkg::sums_t       sums,
  output logic                  sums_valid,
  input  wire logic             sums_ready
);
  import cosd_pkg::*;

  localparam logic signed [SUM_W-1:0] DOT_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] DOT_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [SUM_W-1:0] NORM_MAX = {SUM_W{1'b1}};

  logic signed [SUM_W-1:0] dot_r, dot_nxt;
  logic [SUM_W-1:0] an_r, an_nxt, bn_r, bn_nxt;
  logic signed [ELEM_BITS-1:0] a, b;
  logic signed [2*ELEM_BITS-1:0] pab;
  logic [2*ELEM_BITS-1:0] paa, pbb;
  logic signed [SUM_W:0] dsum;
  logic [SUM_W:0] asum, bsum;
  logic acc;

  assign a = in_data.a_elem[ELEM_BITS-1:0];
  assign b = in_data.b_elem[ELEM_BITS-1:0];
  assign in_ready = sums_ready || !in_data.last;
  assign acc = in_valid && in_ready;

  always_comb begin
    pab = a * b;
    paa = (2*ELEM_BITS)'(a * a);
    pbb = (2*ELEM_BITS)'(b * b);
    dsum = {dot_r[SUM_W-1], dot_r} + (SUM_W+1)'(pab);
    asum = {1'b0, an_r} + (SUM_W+1)'(paa);
    bsum = {1'b0, bn_r} + (SUM_W+1)'(pbb);
    if (dsum > (SUM_W+1)'(DOT_MAX)) dot_nxt = DOT_MAX;
    else if (dsum < $signed({1'b1, DOT_MIN})) dot_nxt = DOT_MIN;
    else dot_nxt = dsum[SUM_W-1:0];
    an_nxt = asum[SUM_W] ? NORM_MAX : asum[SUM_W-1:0];
    bn_nxt = bsum[SUM_W] ? NORM_MAX : bsum[SUM_W-1:0];
  end

  assign sums_valid = in_valid && in_data.last;
  assign sums.dot = dot_nxt;
  assign sums.a_norm = an_nxt;
  assign sums.b_norm = bn_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_r <= '0;
      an_r <= '0;
      bn_r <= '0;
    end else if (acc) begin
      if (in_data.last) begin
        dot_r <= '0;
        an_r <= '0;
        bn_r <= '0;
      end else begin
        dot_r <= dot_nxt;
        an_r <= an_nxt;
        bn_r <= bn_nxt;
      end
    end
  end
endmodule
`default_nettype wire

>>> rtl/cosd_queue.sv
// Short queue of finished sums between front and back.
`default_nettype none
module cosd_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cosd_pkg::sums_t wr_data,
  input  wire logic            wr_valid,
  output logic                 wr_ready,
  output cosd_pkg::sums_t      rd_data,
  output logic                 rd_valid,
  input  wire logic            rd_ready
);
  import cosd_pkg::*;

  sums_t mem_r [QUEUE_DEPTH];
  logic [0:0] wp_r, rp_r;
  logic [1:0] cnt_r;
  logic wr, rd;

  assign wr_ready = cnt_r != 2'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != 2'd0;
  assign rd_data = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= wp_r + 1'b1;
      if (rd) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
  end
endmodule
`default_nettype wire

>>> rtl/cosd_back.sv
// Back end: normalizes, takes the roots, multiplies and divides for one distance.
`default_nettype none
module cosd_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire cosd_pkg::sums_t sums,
  input  wire logic            sums_valid,
  output logic                 sums_ready,
  output cosd_pkg::out_item_t  out_data,
  output logic                 out_valid,
  input  wire logic            out_ready
);
  import cosd_pkg::*;

  localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

  back_state_t state_r, state_nxt;
  logic [NORM_W-1:0] xa_r, xb_r;
  logic [ROOT_W-1:0] ra_r, rb_r;
  logic [NORM_W+1:0] rema_r, remb_r;
  logic [5:0] ea_r, eb_r;
  logic [4:0] cnt_r;
  logic [47:0] mag_r;
  logic neg_r;
  logic [DEN_W-1:0] den_r;
  logic [62:0] num_r;
  logic [30:0] q_r;
  logic [5:0] ml_r;
  logic [1:0] mstep_r;
  logic [DEN_W-1:0] acc_r;
  out_item_t res_r;
  logic ov_r;

  logic [NORM_W+1:0] ta, tb;
  logic [31:0] rbx;
  logic [63:0] p0;

  assign sums_ready = state_r == ST_IDLE && !ov_r;
  assign out_data = res_r;
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (sums_valid && !ov_r && sums.a_norm != '0 && sums.b_norm != '0)
        state_nxt = ST_NORM;
      ST_NORM: if (xa_r[NORM_W-1:NORM_W-2] != 2'b00 && xb_r[NORM_W-1:NORM_W-2] != 2'b00)
        state_nxt = ST_SQRT;
      ST_SQRT: if (cnt_r == 5'd0) state_nxt = ST_MUL;
      ST_MUL:  if (mstep_r == 2'd3) state_nxt = ST_DIV;
      ST_DIV:  if (cnt_r == 5'd0) state_nxt = ST_DONE;
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    // one restoring root digit per cycle for each norm
    ta = {rema_r[NORM_W-1:0], xa_r[NORM_W-1:NORM_W-2]}
         - {1'b0, ra_r, 2'b01};
    tb = {remb_r[NORM_W-1:0], xb_r[NORM_W-1:NORM_W-2]}
         - {1'b0, rb_r, 2'b01};
    // 16-bit slice of rb times 32-bit ra, accumulated over two steps
    rbx = {1'b0, rb_r};
    p0 = 64'({1'b0, ra_r}) * 64'(rbx[{mstep_r[0], 4'd0} +: 16]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (ov_r && out_ready) ov_r <= 1'b0;
      if (state_r == ST_IDLE && sums_valid && !ov_r
          && (sums.a_norm == '0 || sums.b_norm == '0)) ov_r <= 1'b1;
      if (state_r == ST_DONE) ov_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        xa_r <= NORM_W'(sums.a_norm);
        xb_r <= NORM_W'(sums.b_norm);
        ea_r <= '0;
        eb_r <= '0;
        neg_r <= sums.dot[SUM_W-1];
        mag_r <= sums.dot[SUM_W-1] ? 48'(-sums.dot) : sums.dot;
        ra_r <= '0;
        rb_r <= '0;
        rema_r <= '0;
        remb_r <= '0;
        cnt_r <= 5'd30;
        // load a fresh result only while the output register is free;
        // zero norms take the forced result and never leave idle
        if (sums_valid && !ov_r) begin
          res_r.distance <= 32'(ONE_Q30);
          res_r.zero_norm <= sums.a_norm == '0 || sums.b_norm == '0;
        end
      end
      ST_NORM: begin
        if (xa_r[NORM_W-1:NORM_W-2] == 2'b00) begin
          xa_r <= xa_r << 2;
          ea_r <= ea_r + 6'd2;
        end
        if (xb_r[NORM_W-1:NORM_W-2] == 2'b00) begin
          xb_r <= xb_r << 2;
          eb_r <= eb_r + 6'd2;
        end
      end
      ST_SQRT: begin
        xa_r <= xa_r << 2;
        xb_r <= xb_r << 2;
        if (!ta[NORM_W+1]) begin
          rema_r <= ta;
          ra_r <= {ra_r[ROOT_W-2:0], 1'b1};
        end else begin
          rema_r <= {rema_r[NORM_W-1:0], xa_r[NORM_W-1:NORM_W-2]};
          ra_r <= {ra_r[ROOT_W-2:0], 1'b0};
        end
        if (!tb[NORM_W+1]) begin
          remb_r <= tb;
          rb_r <= {rb_r[ROOT_W-2:0], 1'b1};
        end else begin
          remb_r <= {remb_r[NORM_W-1:0], xb_r[NORM_W-1:NORM_W-2]};
          rb_r <= {rb_r[ROOT_W-2:0], 1'b0};
        end
        cnt_r <= cnt_r - 5'd1;
        mstep_r <= '0;
        acc_r <= '0;
        ml_r <= 6'(({1'b0, ea_r} + {1'b0, eb_r}) >> 1);
      end
      ST_MUL: begin
        mstep_r <= mstep_r + 2'd1;
        if (mstep_r == 2'd0) acc_r <= DEN_W'(p0);
        if (mstep_r == 2'd1) acc_r <= acc_r + DEN_W'(p0 << 16);
        if (mstep_r == 2'd2) begin
          den_r <= acc_r;
          num_r <= (mag_r >> (6'd62 - ml_r)) != '0 ? {63{1'b1}}
                   : 63'(64'(mag_r) << ml_r);
        end
        if (mstep_r == 2'd3) begin
          q_r <= '0;
          cnt_r <= 5'd30;
          if (num_r >= 63'(den_r)) begin
            res_r.distance <= neg_r ? 32'(ONE_Q30 << 1) : 32'd0;
            cnt_r <= 5'd0;
          end
        end
      end
      ST_DIV: begin
        if (cnt_r != 5'd0 && num_r < 63'(den_r) || cnt_r != 5'd0) begin
          if ({num_r[61:0], 1'b0} >= 63'(den_r)) begin
            num_r <= {num_r[61:0], 1'b0} - 63'(den_r);
            q_r <= {q_r[29:0], 1'b1};
          end else begin
            num_r <= {num_r[61:0], 1'b0};
            q_r <= {q_r[29:0], 1'b0};
          end
          cnt_r <= cnt_r - 5'd1;
        end
      end
      ST_DONE: begin
        if (res_r.distance == 32'(ONE_Q30))
          res_r.distance <= neg_r ? 32'(ONE_Q30 + 64'(q_r)) : 32'(ONE_Q30 - 64'(q_r));
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

>>> rtl/cosine_distance.sv
// Top level of the streaming cosine distance block.
// The block takes one element pair of two Q1.15 vectors per cycle, unless a last
// pair waits for room in the queue, and keeps the dot product and both squared
// norms in 48-bit saturating sums. On the pair flagged last it hands the sums
// through a two-entry queue to a back end that normalizes each norm, takes both
// square roots one digit a cycle, forms their product in four steps and divides
// one quotient bit a cycle, skipping the division when the similarity clamps, to
// yield a Q2.30 distance. Streaming of the next vector goes on meanwhile; only
// its last pair waits while the queue is full. Either norm zero gives 1.0 with
// zero_norm set, passing through the queue into the output register while the
// back end stays idle.
`default_nettype none
module cosine_distance (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire cosd_pkg::in_item_t  in_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output cosd_pkg::out_item_t      out_data,
  output logic                     out_valid,
  input  wire logic                out_ready
);
  import cosd_pkg::*;

  sums_t f_sums, b_sums;
  logic f_valid, f_ready, b_valid, b_ready;

  // Accumulate element pairs; push sums on the last one.
  cosd_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .sums(f_sums), .sums_valid(f_valid), .sums_ready(f_ready)
  );

  // Hold finished sums while the back end is busy.
  cosd_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_data(f_sums), .wr_valid(f_valid), .wr_ready(f_ready),
    .rd_data(b_sums), .rd_valid(b_valid), .rd_ready(b_ready)
  );

  // Evaluate the distance and hold it in the output register.
  cosd_back u_back (
    .clk(clk), .rst_n(rst_n),
    .sums(b_sums), .sums_valid(b_valid), .sums_ready(b_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );
endmodule
`default_nettype wire

>>> bench/cosine_distance_tb.sv
// Testbench for the streaming cosine distance block: scoreboard check against a predictor.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: keeps the running sums and holds the distances they predict.
class cosd_scoreboard;
  logic signed [47:0] dot_acc;
  logic [47:0] a_norm_acc;
  logic [47:0] b_norm_acc;
  cosd_pkg::out_item_t pending_dist[$];
  int errors;

  function new();
    dot_acc = '0;
    a_norm_acc = '0;
    b_norm_acc = '0;
    errors = 0;
  endfunction

  // Normalize a norm sum to [2^60, 2^62) by an even shift and take its root.
  static function logic [63:0] norm_root(input logic [63:0] n, output int shift);
    logic [63:0] x;
    logic [63:0] r;
    logic [63:0] bit_v;
    x = n;
    shift = 0;
    while (x < (64'd1 << 60)) begin
      x = x << 2;
      shift += 2;
    end
    r = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= r + bit_v) begin
        x = x - (r + bit_v);
        r = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return r;
  endfunction

  function void note_item(cosd_pkg::in_item_t it);
    logic signed [63:0] a;
    logic signed [63:0] b;
    logic signed [63:0] d;
    logic [63:0] s;
    logic [63:0] sa;
    logic [63:0] sb;
    logic [63:0] den;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] r;
    int ea;
    int eb;
    int k;
    cosd_pkg::out_item_t res;
    a = it.a_elem;
    b = it.b_elem;
    d = 64'(dot_acc) + a * b;
    if (d > 64'sh7FFF_FFFF_FFFF) d = 64'sh7FFF_FFFF_FFFF;
    if (d < -64'sh8000_0000_0000) d = -64'sh8000_0000_0000;
    dot_acc = d[47:0];
    s = {16'd0, a_norm_acc} + 64'(a * a);
    a_norm_acc = (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
    s = {16'd0, b_norm_acc} + 64'(b * b);
    b_norm_acc = (s > 64'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : s[47:0];
    if (!it.last) return;
    if (a_norm_acc == 0 || b_norm_acc == 0) begin
      res.distance = 32'h4000_0000;
      res.zero_norm = 1'b1;
    end else begin
      sa = norm_root({16'd0, a_norm_acc}, ea);
      sb = norm_root({16'd0, b_norm_acc}, eb);
      den = sa * sb;
      mag = dot_acc < 0 ? 64'(-64'(dot_acc)) : 64'(dot_acc);
      k = (ea + eb) / 2;
      if ((mag >> (62 - k)) != 0) begin
        q = 64'd1 << 30;
      end else if ((mag << k) >= den) begin
        q = 64'd1 << 30;
      end else begin
        r = mag << k;
        q = 0;
        repeat (30) begin
          r = r << 1;
          q = q << 1;
          if (r >= den) begin
            r = r - den;
            q[0] = 1'b1;
          end
        end
      end
      s = dot_acc < 0 ? (64'd1 << 30) + q : (64'd1 << 30) - q;
      res.distance = s[31:0];
      res.zero_norm = 1'b0;
    end
    pending_dist.push_back(res);
    dot_acc = '0;
    a_norm_acc = '0;
    b_norm_acc = '0;
  endfunction

  function void check_result(cosd_pkg::out_item_t got);
    cosd_pkg::out_item_t want;
    if (pending_dist.size() == 0) begin
      $error("unexpected result distance=%h zero_norm=%b", got.distance, got.zero_norm);
      errors++;
      return;
    end
    want = pending_dist.pop_front();
    if (got.distance !== want.distance) begin
      $error("distance: expected %h actual %h", want.distance, got.distance);
      errors++;
    end
    if (got.zero_norm !== want.zero_norm) begin
      $error("zero_norm: expected %b actual %b", want.zero_norm, got.zero_norm);
      errors++;
    end
  endfunction
endclass

module cosine_distance_tb;
  import cosd_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  in_item_t in_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  out_item_t out_data;
  logic out_valid;
  logic out_ready = 1'b0;

  // Idle rate in percent for each side; zero gives a stretch with no gaps.
  int send_idle_pct = 32;
  int recv_idle_pct = 32;
  int stall_cycles = 0;
  int remaining_items = 0;

  cosd_scoreboard sb = new();

  cosine_distance dut (
    .clk(clk), .rst_n(rst_n),
    .in_data(in_data), .in_valid(in_valid), .in_ready(in_ready),
    .out_data(out_data), .out_valid(out_valid), .out_ready(out_ready)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Note accepted items and check accepted results at the edge; count stalls.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_item(in_data);
      if (out_valid && out_ready) sb.check_result(out_data);
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
    end
  end

  // Receiver: drop ready at random.
  always @(posedge clk) begin
    if (rst_n) out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Present one item and hold it until accepted; idle first at random.
  task automatic send_item(input logic signed [15:0] a, input logic signed [15:0] b,
                           input logic lst);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_data <= '{a_elem: a, b_elem: b, last: lst};
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_elem();
    case ($urandom_range(9))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'sh0000;
      3: return 16'($urandom_range(7)) - 16'sd4;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one vector pair of the given length with a chosen flavor.
  task automatic send_vector(input int len, input int flavor);
    logic signed [15:0] a;
    logic signed [15:0] b;
    for (int i = 0; i < len; i++) begin
      a = rand_elem();
      case (flavor)
        0: b = a;
        1: b = -a;
        2: b = 16'sh0000;
        default: b = rand_elem();
      endcase
      send_item(a, b, i == len - 1);
    end
  endtask

  // Drop valid and hold off until every expected result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_dist.size() != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes, single pairs, zero norms, parallel and opposite vectors.
    send_item(16'sh7FFF, 16'sh7FFF, 1'b1);
    send_item(16'sh8000, 16'sh8000, 1'b1);
    send_item(16'sh8000, 16'sh7FFF, 1'b1);
    send_item(16'sh0000, 16'sh1234, 1'b1);
    send_item(16'sh4321, 16'sh0000, 1'b1);
    send_item(16'sh0000, 16'sh0000, 1'b1);
    send_item(16'sh0001, 16'shFFFF, 1'b1);
    send_item(16'sh0001, 16'sh0000, 1'b0);
    send_item(16'sh0000, 16'sh0001, 1'b1);
    send_item(16'sh7FFF, 16'sh0001, 1'b0);
    send_item(16'sh0001, 16'sh7FFF, 1'b1);
    send_item(16'sh5555, 16'shAAAA, 1'b0);
    send_item(16'shAAAA, 16'sh5555, 1'b1);
    send_item(16'sh0003, 16'sh0004, 1'b0);
    send_item(16'sh0004, 16'sh0003, 1'b1);
    // Hold off until every distance has come back.
    wait_drained();

    // Random: mostly short vectors, a few long ones, with idle phases varied.
    remaining_items = 2000;
    while (remaining_items > 0) begin
      int len;
      int flavor;
      if ($urandom_range(99) < 3) len = $urandom_range(200, 600);
      else len = $urandom_range(1, 12);
      flavor = $urandom_range(5);
      if (remaining_items > 1300 && remaining_items < 1600) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else begin
        send_idle_pct = 32;
        recv_idle_pct = 32;
      end
      if ($urandom_range(49) == 0) wait_drained();
      send_vector(len, flavor);
      remaining_items -= len;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending_dist.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
